### rtl/core/vmd_pkg.sv
`default_nettype none

package vmd_pkg;

  localparam int MAX_WIDTH      = 4096;
  localparam int ADDR_BITS      = 12;
  localparam int SAMPLE_BITS    = 16;
  localparam int WIDTH_BITS     = 13;
  localparam int HEIGHT_BITS    = 16;
  localparam int FIFO_DEPTH     = 8;
  localparam int FIFO_PTR_BITS  = 3;
  localparam int FIFO_LVL_BITS  = 4;
  localparam int CFG_DATA_BITS  = 16;
  localparam int CFG_INDEX_BITS = 2;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [ADDR_BITS-1:0]          addr_t;
  typedef logic [FIFO_LVL_BITS-1:0]      level_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_LINE_WIDTH   = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_CEILING      = 2'd2,
    REG_SKIP_ZERO    = 2'd3
  } reg_index_t;

  typedef struct packed {
    sample_t pixel_out;
    logic    end_of_run;
    logic    end_of_frame;
  } result_t;

  typedef struct packed {
    sample_t older;
    sample_t newer;
  } line_pair_t;

  localparam logic [WIDTH_BITS-1:0]  LINE_WIDTH_RST   = 13'd256;
  localparam logic [HEIGHT_BITS-1:0] FRAME_HEIGHT_RST = 16'd256;
  localparam sample_t                CEILING_RST      = 16'sd32650;

endpackage

`default_nettype wire

### rtl/core/vmd_if.sv
`default_nettype none

interface vmd_sample_if;
  logic             valid;
  logic             ready;
  vmd_pkg::sample_t pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink (input valid, input pixel_in, output ready);
endinterface

interface vmd_result_if;
  logic             valid;
  logic             ready;
  vmd_pkg::sample_t pixel_out;
  logic             end_of_run;
  logic             end_of_frame;

  modport source (output valid, output pixel_out, output end_of_run, output end_of_frame,
                  input ready);
  modport sink (input valid, input pixel_out, input end_of_run, input end_of_frame,
                output ready);
endinterface

`default_nettype wire

### rtl/core/vertical_median3_despike.sv
// vertical_median3_despike: 3-tap vertical median filter on a raster stream.
//
// samples (sink): one signed pixel per item, raster order, taken on valid & ready.
// results (source): filtered pixels in raster order, one row behind the input.
//   Interior pixels get the median of above/centre/below if all are eligible, else
//   the larger of two eligible ones, else centre; border rows and columns pass
//   through. The last input row gives two results per item (row above, then pixel),
//   end_of_run on the second; end_of_frame marks the final pixel of the frame.
// wr_en/wr_index/wr_data: register writes, only while the block is idle.
//
// The first result of an item is registered in the s1 stage and then in the output
// FIFO before it is offered. Throughput: one item per cycle while the FIFO has
// room; on the last row the result port (one result per cycle) limits it, since
// each item then yields two results. A line buffer with one read and one write
// port (4096 x 32 bit) is read at accept and rewritten the next cycle.
// Stall: results queue in an 8-entry output FIFO; samples.ready drops when the
// FIFO could not hold two more results for the item in flight and a new one.
// Reset: counters and FIFO clear and registers take their defaults; no clearing
// pass is needed, the first row is never filtered.

`default_nettype none

module vertical_median3_despike (
  input  wire                                 clk,
  input  wire                                 rst,
  vmd_sample_if.sink                          samples,
  vmd_result_if.source                        results,
  input  wire                                 wr_en,
  input  wire [vmd_pkg::CFG_INDEX_BITS-1:0]   wr_index,
  input  wire [vmd_pkg::CFG_DATA_BITS-1:0]    wr_data
);
  import vmd_pkg::*;

  logic [WIDTH_BITS-1:0]  line_width;
  logic [HEIGHT_BITS-1:0] frame_height;
  sample_t                ceiling;
  logic                   skip_zero;

  logic [ADDR_BITS-1:0]   col_cnt;
  logic [HEIGHT_BITS-1:0] row_cnt;

  logic [WIDTH_BITS-1:0]  w_sat;
  logic [HEIGHT_BITS-1:0] h_sat;
  logic                   last_col;
  logic                   last_row;
  logic                   in_acc;

  logic                   s1_valid;
  sample_t                s1_px;
  addr_t                  s1_idx;
  logic                   s1_has_prev;
  logic                   s1_border;
  logic                   s1_last_row;
  logic                   s1_last_col;

  line_pair_t             rd_pair;
  line_pair_t             wr_pair;
  sample_t                filt;
  result_t                res_prev;
  result_t                res_self;
  result_t                wr0;
  logic [1:0]             wr_count;
  level_t                 level;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width   <= LINE_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
      ceiling      <= CEILING_RST;
      skip_zero    <= 1'b1;
    end else if (wr_en) begin
      case (reg_index_t'(wr_index))
        REG_LINE_WIDTH:   line_width   <= wr_data[WIDTH_BITS-1:0];
        REG_FRAME_HEIGHT: frame_height <= wr_data[HEIGHT_BITS-1:0];
        REG_CEILING:      ceiling      <= sample_t'(wr_data);
        REG_SKIP_ZERO:    skip_zero    <= wr_data[0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    if (line_width < WIDTH_BITS'(3)) begin
      w_sat = WIDTH_BITS'(3);
    end else if (line_width > WIDTH_BITS'(MAX_WIDTH)) begin
      w_sat = WIDTH_BITS'(MAX_WIDTH);
    end else begin
      w_sat = line_width;
    end
    h_sat    = (frame_height < HEIGHT_BITS'(3)) ? HEIGHT_BITS'(3) : frame_height;
    last_col = ({1'b0, col_cnt} + WIDTH_BITS'(1)) >= w_sat;
    last_row = ({1'b0, row_cnt} + (HEIGHT_BITS+1)'(1)) >= {1'b0, h_sat};
  end

  // reserve room for up to two results of the item in flight and two of the new one
  assign samples.ready = ({1'b0, level} + (s1_valid ? (FIFO_LVL_BITS+1)'(2) : '0))
                         <= (FIFO_LVL_BITS+1)'(FIFO_DEPTH - 2);
  assign in_acc = samples.valid && samples.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt  <= '0;
      row_cnt  <= '0;
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_acc;
      if (in_acc) begin
        if (last_col) begin
          col_cnt <= '0;
          row_cnt <= last_row ? '0 : row_cnt + HEIGHT_BITS'(1);
        end else begin
          col_cnt <= col_cnt + ADDR_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_px       <= samples.pixel_in;
      s1_idx      <= col_cnt;
      s1_has_prev <= (row_cnt != '0);
      s1_border   <= (row_cnt == HEIGHT_BITS'(1)) || (col_cnt == '0) || last_col;
      s1_last_row <= last_row;
      s1_last_col <= last_col;
    end
  end

  assign wr_pair.older = rd_pair.newer;
  assign wr_pair.newer = s1_px;

  vmd_line_buf u_line_buf (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_addr (col_cnt),
    .rd_data (rd_pair),
    .wr_en   (s1_valid),
    .wr_addr (s1_idx),
    .wr_data (wr_pair)
  );

  vmd_median u_median (
    .above     (rd_pair.older),
    .centre    (rd_pair.newer),
    .below     (s1_px),
    .ceiling   (ceiling),
    .skip_zero (skip_zero),
    .border    (s1_border),
    .result    (filt)
  );

  always_comb begin
    res_prev.pixel_out    = filt;
    res_prev.end_of_run   = !s1_last_row;
    res_prev.end_of_frame = 1'b0;
    res_self.pixel_out    = s1_px;
    res_self.end_of_run   = 1'b1;
    res_self.end_of_frame = s1_last_col;
    wr0      = s1_has_prev ? res_prev : res_self;
    wr_count = s1_valid ? (2'(s1_has_prev) + 2'(s1_last_row)) : 2'd0;
  end

  vmd_out_fifo u_out_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_count (wr_count),
    .wr0      (wr0),
    .wr1      (res_self),
    .level    (level),
    .results  (results)
  );

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    level <= FIFO_LVL_BITS'(FIFO_DEPTH))
    else $error("output queue overflow");

  a_room_on_accept: assert property (@(posedge clk) disable iff (rst)
    in_acc |-> level <= FIFO_LVL_BITS'(FIFO_DEPTH - 2))
    else $error("item accepted without queue room");

  a_stage_follows_accept: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> s1_valid && s1_idx == $past(col_cnt))
    else $error("line buffer write lost its item");

  a_result_emitted: assert property (@(posedge clk) disable iff (rst)
    s1_valid && (s1_has_prev || s1_last_row) |=> results.valid)
    else $error("item produced no result");

endmodule

`default_nettype wire

### rtl/core/vmd_line_buf.sv
`default_nettype none

module vmd_line_buf (
  input  wire                  clk,
  input  wire                  rd_en,
  input  vmd_pkg::addr_t       rd_addr,
  output vmd_pkg::line_pair_t  rd_data,
  input  wire                  wr_en,
  input  vmd_pkg::addr_t       wr_addr,
  input  vmd_pkg::line_pair_t  wr_data
);
  import vmd_pkg::*;

  line_pair_t mem [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### rtl/core/vmd_median.sv
`default_nettype none

module vmd_median (
  input  vmd_pkg::sample_t above,
  input  vmd_pkg::sample_t centre,
  input  vmd_pkg::sample_t below,
  input  vmd_pkg::sample_t ceiling,
  input  wire              skip_zero,
  input  wire              border,
  output vmd_pkg::sample_t result
);
  import vmd_pkg::*;

  logic    ea, eb, ec;
  sample_t min_ab, max_ab, max_ac, max_bc, med;

  always_comb begin
    ea = (above < ceiling) && !(skip_zero && above == '0);
    eb = (centre < ceiling) && !(skip_zero && centre == '0);
    ec = (below < ceiling) && !(skip_zero && below == '0);

    min_ab = (above < centre) ? above : centre;
    max_ab = (above < centre) ? centre : above;
    max_ac = (above > below) ? above : below;
    max_bc = (centre > below) ? centre : below;
    // median of three = max(min(a,b), min(max(a,b),c))
    med = (max_ab < below) ? max_ab : below;
    med = (min_ab > med) ? min_ab : med;

    if (border) begin
      result = centre;
    end else if (ea && eb && ec) begin
      result = med;
    end else if (ea && eb) begin
      result = max_ab;
    end else if (ea && ec) begin
      result = max_ac;
    end else if (eb && ec) begin
      result = max_bc;
    end else begin
      result = centre;
    end
  end

endmodule

`default_nettype wire

### rtl/core/vmd_out_fifo.sv
`default_nettype none

module vmd_out_fifo (
  input  wire               clk,
  input  wire               rst,
  input  wire [1:0]         wr_count,
  input  vmd_pkg::result_t  wr0,
  input  vmd_pkg::result_t  wr1,
  output vmd_pkg::level_t   level,
  vmd_result_if.source      results
);
  import vmd_pkg::*;

  result_t                  mem [FIFO_DEPTH];
  logic [FIFO_PTR_BITS-1:0] wr_ptr;
  logic [FIFO_PTR_BITS-1:0] rd_ptr;
  logic                     pop;
  result_t                  head;

  assign head                 = mem[rd_ptr];
  assign results.valid        = (level != '0);
  assign results.pixel_out    = head.pixel_out;
  assign results.end_of_run   = head.end_of_run;
  assign results.end_of_frame = head.end_of_frame;
  assign pop                  = results.valid && results.ready;

  always_ff @(posedge clk) begin
    if (wr_count != 2'd0) begin
      mem[wr_ptr] <= wr0;
    end
    if (wr_count == 2'd2) begin
      mem[wr_ptr + FIFO_PTR_BITS'(1)] <= wr1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_PTR_BITS'(wr_count);
      rd_ptr <= rd_ptr + FIFO_PTR_BITS'(pop);
      level  <= level + FIFO_LVL_BITS'(wr_count) - FIFO_LVL_BITS'(pop);
    end
  end

endmodule

`default_nettype wire

### sim/vertical_median3_despike_tb.sv
module vertical_median3_despike_tb;
  import vmd_pkg::*;

  localparam int DRAIN_CYCLES  = 8;
  localparam int RANDOM_ITEMS  = 1300;
  localparam int NUM_DIRECTED  = 29;
  localparam int WIDE_ITEMS    = 40;

  typedef enum logic {STEP_PIXEL, STEP_WRITE} step_kind_t;
  typedef enum logic [1:0] {DRAIN_FREE, DRAIN_RANDOM, DRAIN_PERIODIC, DRAIN_BURSTY} drain_mode_t;

  typedef struct packed {
    step_kind_t  kind;
    reg_index_t  reg_sel;
    logic [15:0] value;
    logic        typed;
    logic [1:0]  n_res;
    result_t     res0;
    result_t     res1;
  } directed_step_t;

  localparam result_t NO_RESULT = '0;

  // reset-default row, then width/height shrink mid-row, then a filtered frame
  localparam directed_step_t DIRECTED_STEPS [NUM_DIRECTED] = '{
    '{STEP_PIXEL, REG_LINE_WIDTH, 16'h8000, 1'b1, 2'd0, NO_RESULT, NO_RESULT},
    '{STEP_PIXEL, REG_LINE_WIDTH, 16'd32700, 1'b1, 2'd0, NO_RESULT, NO_RESULT},
    '{STEP_PIXEL, REG_LINE_WIDTH, 16'h7FFF, 1'b1, 2'd0, NO_RESULT, NO_RESULT},
    '{STEP_PIXEL, REG_LINE_WIDTH, 16'd11, 1'b1, 2'd0, NO_RESULT, NO_RESULT},
    '{STEP_PIXEL, REG_LINE_WIDTH, 16'd12, 1'b1, 2'd0, NO_RESULT, NO_RESULT},
    '{STEP_WRITE, REG_LINE_WIDTH, 16'd0, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
    '{STEP_WRITE, REG_FRAME_HEIGHT, 16'd2, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
    '{STEP_PIXEL, REG_LINE_WIDTH, 16'd13, 1'b1, 2'd0, NO_RESULT, NO_RESULT},
    '{STEP_PIXEL, REG_LINE_WIDTH, 16'd5, 1'b1, 2'd1,
      '{16'sh8000, 1'b1, 1'b0}, NO_RESULT},
    '{STEP_PIXEL, REG_LINE_WIDTH, 16'd0, 1'b1, 2'd1,
      '{16'sd32700, 1'b1, 1'b0}, NO_RESULT},
    '{STEP_PIXEL, REG_LINE_WIDTH, 16'd7, 1'b1, 2'd1,
      '{16'sh7FFF, 1'b1, 1'b0}, NO_RESULT},
    '{STEP_PIXEL, REG_LINE_WIDTH, 16'd1, 1'b1, 2'd2,
      '{16'sd5, 1'b0, 1'b0}, '{16'sd1, 1'b1, 1'b0}},
    // nothing eligible under the default ceiling with zeros skipped
    '{STEP_PIXEL, REG_LINE_WIDTH, 16'd32650, 1'b1, 2'd2,
      '{16'sd0, 1'b0, 1'b0}, '{16'sd32650, 1'b1, 1'b0}},
    '{STEP_PIXEL, REG_LINE_WIDTH, 16'h8000, 1'b1, 2'd2,
      '{16'sd7, 1'b0, 1'b0}, '{16'sh8000, 1'b1, 1'b1}},
    '{STEP_WRITE, REG_CEILING, 16'd100, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
    '{STEP_WRITE, REG_SKIP_ZERO, 16'hFFFE, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
    '{STEP_WRITE, REG_FRAME_HEIGHT, 16'd4, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
    '{STEP_PIXEL, REG_LINE_WIDTH, 16'd3, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
    '{STEP_PIXEL, REG_LINE_WIDTH, 16'd3, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
    '{STEP_PIXEL, REG_LINE_WIDTH, 16'd3, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
    '{STEP_PIXEL, REG_LINE_WIDTH, 16'd9, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
    '{STEP_PIXEL, REG_LINE_WIDTH, 16'd3, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
    '{STEP_PIXEL, REG_LINE_WIDTH, 16'd9, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
    '{STEP_PIXEL, REG_LINE_WIDTH, 16'd4, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
    '{STEP_PIXEL, REG_LINE_WIDTH, 16'd0, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
    '{STEP_PIXEL, REG_LINE_WIDTH, 16'd4, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
    '{STEP_PIXEL, REG_LINE_WIDTH, 16'd1, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
    '{STEP_PIXEL, REG_LINE_WIDTH, 16'd200, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
    '{STEP_PIXEL, REG_LINE_WIDTH, 16'd1, 1'b0, 2'd0, NO_RESULT, NO_RESULT}
  };

  logic clk;
  logic rst = 1'b1;
  logic wr_en = 1'b0;
  logic [CFG_INDEX_BITS-1:0] wr_index = '0;
  logic [CFG_DATA_BITS-1:0]  wr_data = '0;

  vmd_sample_if sample_bus ();
  vmd_result_if result_bus ();

  vertical_median3_despike dut (
    .clk      (clk),
    .rst      (rst),
    .samples  (sample_bus),
    .results  (result_bus),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  // filter copy: line memories, raster position, registers
  sample_t older_line [MAX_WIDTH];
  sample_t newer_line [MAX_WIDTH];
  logic [ADDR_BITS-1:0]   col_cnt = '0;
  logic [HEIGHT_BITS-1:0] row_cnt = '0;
  logic [WIDTH_BITS-1:0]  cfg_width = 13'd256;
  logic [HEIGHT_BITS-1:0] cfg_height = 16'd256;
  sample_t                cfg_ceiling = 16'sd32650;
  logic                   cfg_skip_zero = 1'b1;

  result_t outgoing_pixels [$];

  int items_sent = 0;
  int results_seen = 0;
  int writes_done = 0;
  int mismatch_count = 0;
  int burst_left = 0;
  int phase_count = 0;

  drain_mode_t drain_mode = DRAIN_FREE;
  int drain_left = 0;
  int hold_left = 0;
  logic hold_level = 1'b1;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    sample_bus.valid = 1'b0;
    sample_bus.pixel_in = '0;
    result_bus.ready = 1'b0;
  end

  function automatic bit is_eligible(sample_t v);
    if (v >= cfg_ceiling) return 1'b0;
    if (cfg_skip_zero && v == 0) return 1'b0;
    return 1'b1;
  endfunction

  function automatic sample_t window_median(sample_t above, sample_t centre, sample_t below);
    sample_t v [3];
    sample_t lo, hi;
    int n;
    n = 0;
    if (is_eligible(above)) begin v[n] = above; n++; end
    if (is_eligible(centre)) begin v[n] = centre; n++; end
    if (is_eligible(below)) begin v[n] = below; n++; end
    if (n < 2) return centre;
    if (n == 2) return (v[0] > v[1]) ? v[0] : v[1];
    lo = (v[0] < v[1]) ? v[0] : v[1];
    hi = (v[0] < v[1]) ? v[1] : v[0];
    if (v[2] <= lo) return lo;
    if (v[2] >= hi) return hi;
    return v[2];
  endfunction

  task automatic advance_window(input sample_t px, input bit record);
    int w, h, c, r;
    bit last_col, last_row;
    result_t res;
    w = cfg_width;
    if (w < 3) w = 3;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    h = cfg_height;
    if (h < 3) h = 3;
    c = col_cnt;
    r = row_cnt;
    last_col = (c + 1 >= w);
    last_row = (r + 1 >= h);
    if (r >= 1) begin
      if (r == 1 || c == 0 || last_col)
        res.pixel_out = newer_line[c];
      else
        res.pixel_out = window_median(older_line[c], newer_line[c], px);
      res.end_of_run = !last_row;
      res.end_of_frame = 1'b0;
      if (record) outgoing_pixels.push_back(res);
    end
    if (last_row) begin
      res = '{px, 1'b1, last_col};
      if (record) outgoing_pixels.push_back(res);
    end
    older_line[c] = newer_line[c];
    newer_line[c] = px;
    if (last_col) begin
      col_cnt = '0;
      row_cnt = last_row ? '0 : HEIGHT_BITS'(r + 1);
    end else begin
      col_cnt = ADDR_BITS'(c + 1);
    end
  endtask

  task automatic send_pixel(input sample_t px, input bit typed, input logic [1:0] n_res,
                            input result_t res0, input result_t res1);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        sample_bus.valid <= 1'b0;
      end
      burst_left = $urandom_range(1, 60);
    end
    @(negedge clk);
    sample_bus.valid <= 1'b1;
    sample_bus.pixel_in <= px;
    do @(posedge clk); while (!sample_bus.ready);
    burst_left--;
    items_sent++;
    advance_window(px, !typed);
    if (typed && n_res >= 1) outgoing_pixels.push_back(res0);
    if (typed && n_res == 2) outgoing_pixels.push_back(res1);
  endtask

  task automatic settle();
    @(negedge clk);
    sample_bus.valid <= 1'b0;
    while (outgoing_pixels.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input reg_index_t sel, input logic [15:0] data);
    @(negedge clk);
    wr_en <= 1'b1;
    wr_index <= sel;
    wr_data <= data;
    @(negedge clk);
    wr_en <= 1'b0;
    case (sel)
      REG_LINE_WIDTH:   cfg_width = data[WIDTH_BITS-1:0];
      REG_FRAME_HEIGHT: cfg_height = data;
      REG_CEILING:      cfg_ceiling = data;
      REG_SKIP_ZERO:    cfg_skip_zero = data[0];
      default: ;
    endcase
    writes_done++;
  endtask

  task automatic program_filter(input logic [15:0] width, input logic [15:0] height,
                                input logic [15:0] ceil_val, input logic [15:0] skip_val);
    settle();
    write_reg(REG_LINE_WIDTH, width);
    write_reg(REG_FRAME_HEIGHT, height);
    write_reg(REG_CEILING, ceil_val);
    write_reg(REG_SKIP_ZERO, skip_val);
  endtask

  function automatic sample_t random_pixel();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 5) return sample_t'(int'($urandom_range(0, 16)) - 8);
    if (pick < 7) return '0;
    if (pick < 9) return cfg_ceiling + sample_t'(int'($urandom_range(0, 2)) - 1);
    if (pick == 9) return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
    return sample_t'($urandom());
  endfunction

  function automatic logic [15:0] random_ceiling();
    if (phase_count == 0) return 16'h8000;
    if (phase_count == 1) return 16'h7FFF;
    if (phase_count == 2) return 16'h0000;
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2, 3, 4: return 16'(int'($urandom_range(0, 20)) - 10);
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [15:0] random_skip();
    logic sz;
    sz = (phase_count < 2) ? phase_count[0] : 1'($urandom());
    return {15'($urandom()), sz};
  endfunction

  task automatic run_to_boundary();
    do send_pixel(random_pixel(), 1'b0, 2'd0, NO_RESULT, NO_RESULT);
    while (col_cnt != 0 || row_cnt != 0);
  endtask

  task automatic run_frame_phase();
    logic [15:0] w, h;
    case ($urandom_range(0, 9))
      0: w = 16'($urandom_range(0, 2));
      1: w = 16'($urandom_range(13, 40));
      2: w = 16'hE000 | 16'($urandom_range(3, 12));
      default: w = 16'($urandom_range(3, 12));
    endcase
    case ($urandom_range(0, 6))
      0: h = 16'($urandom_range(0, 2));
      1: h = 16'($urandom_range(9, 20));
      default: h = 16'($urandom_range(3, 8));
    endcase
    program_filter(w, h, random_ceiling(), random_skip());
    repeat ($urandom_range(1, 3)) run_to_boundary();
    phase_count++;
  endtask

  // shrink width and height mid-frame, so the counters can sit past the new edges
  task automatic run_shrink_phase(input bit tallest);
    int w_big, rows_full, part;
    w_big = $urandom_range(8, 16);
    rows_full = $urandom_range(2, 4);
    part = $urandom_range(1, w_big - 1);
    program_filter(16'(w_big), tallest ? 16'hFFFF : 16'($urandom_range(20, 65535)),
                   random_ceiling(), random_skip());
    repeat (rows_full * w_big + part)
      send_pixel(random_pixel(), 1'b0, 2'd0, NO_RESULT, NO_RESULT);
    settle();
    write_reg(REG_LINE_WIDTH, 16'($urandom_range(3, w_big - 1)));
    write_reg(REG_FRAME_HEIGHT, 16'($urandom_range(3, 5)));
    run_to_boundary();
    phase_count++;
  endtask

  always @(negedge clk) begin
    if (drain_left == 0) begin
      drain_mode = drain_mode_t'($urandom_range(0, 3));
      drain_left = $urandom_range(20, 300);
    end
    drain_left--;
    case (drain_mode)
      DRAIN_FREE:     result_bus.ready <= 1'b1;
      DRAIN_RANDOM:   result_bus.ready <= ($urandom_range(0, 3) != 0);
      DRAIN_PERIODIC: result_bus.ready <= (drain_left % 3 == 0);
      DRAIN_BURSTY: begin
        if (hold_left == 0) begin
          hold_level = !hold_level;
          hold_left = hold_level ? $urandom_range(1, 8) : $urandom_range(1, 12);
        end
        hold_left--;
        result_bus.ready <= hold_level;
      end
      default: result_bus.ready <= 1'b1;
    endcase
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH result %0d %s: got %0d expected %0d", results_seen, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && result_bus.valid && result_bus.ready) begin
      if (outgoing_pixels.size() == 0) begin
        report_mismatch("unexpected", int'($signed(result_bus.pixel_out)), 0);
      end else begin
        want = outgoing_pixels.pop_front();
        if (result_bus.pixel_out !== want.pixel_out)
          report_mismatch("pixel_out", int'($signed(result_bus.pixel_out)),
                          int'($signed(want.pixel_out)));
        if (result_bus.end_of_run !== want.end_of_run)
          report_mismatch("end_of_run", int'(result_bus.end_of_run), int'(want.end_of_run));
        if (result_bus.end_of_frame !== want.end_of_frame)
          report_mismatch("end_of_frame", int'(result_bus.end_of_frame),
                          int'(want.end_of_frame));
      end
      results_seen++;
    end
  end

  initial begin
    directed_step_t step;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      step = DIRECTED_STEPS[i];
      if (step.kind == STEP_WRITE) begin
        settle();
        write_reg(step.reg_sel, step.value);
      end else begin
        send_pixel(sample_t'(step.value), step.typed, step.n_res, step.res0, step.res1);
      end
    end

    run_shrink_phase(1'b1);
    while (items_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 4) == 0) run_shrink_phase(1'b0);
      else run_frame_phase();
    end
    // oversized width: 13-bit value saturates to the buffer depth, then a narrow
    // width takes over within the first row
    program_filter(16'hFFFF, 16'd3, random_ceiling(), random_skip());
    repeat (WIDE_ITEMS) send_pixel(random_pixel(), 1'b0, 2'd0, NO_RESULT, NO_RESULT);
    settle();
    write_reg(REG_LINE_WIDTH, 16'd3);
    run_to_boundary();

    settle();
    $display("Sent %0d items over %0d register writes, checked %0d results;", items_sent,
             writes_done, results_seen);
    $display("line widths 3 to 40 and one clipped to the buffer depth, mid-frame shrinks, %s",
             "ceiling and zero-skip extremes.");
    if (mismatch_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #30_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
